@@ design/shadow_silhouette_edge_extruder_core_macros.svh @@
// Assertion macros shared by the extruder RTL.
`ifndef SHADOW_SILHOUETTE_EDGE_EXTRUDER_CORE_MACROS_SVH
`define SHADOW_SILHOUETTE_EDGE_EXTRUDER_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define SSEE_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define SSEE_NEVER(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);
`else
`define SSEE_ASSERT(lbl, prop, msg)
`define SSEE_NEVER(lbl, expr, msg)
`endif
`endif

@@ design/ssee_pkg.sv @@
// Types and constants of the silhouette edge extruder.
package ssee_pkg;
   localparam int VTX_DEPTH   = 1024;
   localparam int FACE_DEPTH  = 1024;
   localparam int IDX_W       = 10;
   localparam int NB_W        = 11;
   localparam int COORD_W     = 16;
   localparam int FAR_W       = 24;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam logic [FAR_W-1:0] EXTRUDE_FACTOR = 24'd100;
   localparam logic [2:0] CALC_LAST = 3'd4;

   localparam logic [1:0] REG_LIGHT_X = 2'd0;
   localparam logic [1:0] REG_LIGHT_Y = 2'd1;
   localparam logic [1:0] REG_LIGHT_Z = 2'd2;

   typedef enum logic [1:0] {
      CMD_VERTEX = 2'd0,
      CMD_FACE   = 2'd1,
      CMD_QUERY  = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   // index 0 is x, 1 is y, 2 is z
   typedef logic [2:0][COORD_W-1:0] vertex_type;

   typedef struct packed {
      logic [2:0][NB_W-1:0]  nb;
      logic [2:0][IDX_W-1:0] corner;
   } face_type;

   typedef struct packed {
      cmd_type               cmd;
      logic [IDX_W-1:0]      slot;
      vertex_type            pos;
      logic [2:0][IDX_W-1:0] corner;
      logic [2:0][NB_W-1:0]  nb;
   } req_item_type;

   typedef struct packed {
      logic         valid;
      req_item_type item;
   } q_head_type;
endpackage

@@ design/ssee_ram.sv @@
// Generic RAM: one write port, one registered read port.
module ssee_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

@@ design/ssee_front.sv @@
// Front end: takes requests, drops CMD_NONE requests, queues the rest.
`include "shadow_silhouette_edge_extruder_core_macros.svh"
module ssee_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [127:0]        req_tdata,  // slot, pos_x, pos_y, pos_z, corner_a..c, neighbour_a..c
   input  logic [1:0]          req_tuser,  // command
   output ssee_pkg::q_head_type head,
   input  logic                pop
);
   import ssee_pkg::*;

   req_item_type          queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     head_ff, head_in;
   logic [QPTR_W-1:0]     tail_ff, tail_in;
   logic [QPTR_W:0]       count_ff, count_in;
   req_item_type          item;
   logic                  push;

   always_comb begin
      item.cmd    = cmd_type'(req_tuser);
      item.slot   = req_tdata[9:0];
      item.pos    = req_tdata[57:10];
      item.corner = req_tdata[87:58];
      item.nb     = req_tdata[120:88];
   end

   assign req_tready = (count_ff != (QPTR_W+1)'(QUEUE_DEPTH));
   assign push = req_tvalid && req_tready && (item.cmd != CMD_NONE);

   always_comb begin
      head_in  = head_ff + QPTR_W'(pop);
      tail_in  = tail_ff + QPTR_W'(push);
      count_in = count_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[tail_ff] <= item;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.item  = queue_ff[head_ff];

   `SSEE_ASSERT(a_pop_nonempty, pop |-> count_ff != '0, "pop from empty queue")
   `SSEE_NEVER(a_count_range, count_ff > (QPTR_W+1)'(QUEUE_DEPTH), "queue count overflow")
   `SSEE_ASSERT(a_full_stall, count_ff == (QPTR_W+1)'(QUEUE_DEPTH) |-> !push,
      "push into full queue")
endmodule

@@ design/ssee_back.sv @@
// Back end: mesh stores, plane tests and silhouette edge emission.
`include "shadow_silhouette_edge_extruder_core_macros.svh"
module ssee_back (
   input  logic                 clock,
   input  logic                 reset,
   input  ssee_pkg::q_head_type head,
   output logic                 pop,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [1:0]           csr_index,
   input  logic [15:0]          csr_data,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [135:0]         rsp_tdata,  // face_index, near_x/y/z, far_x/y/z
   output logic [2:0]           rsp_tuser,  // edge_slot, endpoint
   output logic                 rsp_tlast
);
   import ssee_pkg::*;

   typedef enum logic [8:0] {
      ST_IDLE    = 9'b000000001,
      ST_FACE_RD = 9'b000000010,
      ST_FACE_WT = 9'b000000100,
      ST_V0      = 9'b000001000,
      ST_V1      = 9'b000010000,
      ST_V2      = 9'b000100000,
      ST_CALC    = 9'b001000000,
      ST_NB      = 9'b010000000,
      ST_EMIT    = 9'b100000000
   } state_type;

   state_type             state_ff, state_in;
   logic [IDX_W-1:0]      cur_face_ff, cur_face_in;
   logic [IDX_W-1:0]      qface_ff, qface_in;
   logic                  self_ff, self_in;
   logic [2:0][IDX_W-1:0] corner_ff, corner_in;
   logic [2:0][NB_W-1:0]  nb_ff, nb_in;
   vertex_type            p_ff, p_in, q_ff, q_in, r_ff, r_in;
   vertex_type [2:0]      vq_ff, vq_in;
   logic [2:0]            sil_ff, sil_in;
   logic [1:0]            nk_ff, nk_in;
   logic [2:0]            cnt_ff, cnt_in;
   logic                  end_ff, end_in;
   logic [COORD_W-1:0]    light_ff [3];
   logic [COORD_W-1:0]    light_in [3];

   // plane test pipeline
   logic signed [16:0]    u_ff [3], w_ff [3], e_ff [3], e2_ff [3], e3_ff [3];
   logic signed [16:0]    u_in [3], w_in [3], e_in [3];
   logic signed [33:0]    m_ff [6], m_in [6];
   logic signed [34:0]    n_ff [3], n_in [3];
   logic signed [51:0]    t_ff [3], t_in [3];
   logic [53:0]           side;
   logic                  lit;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]      rsp_face_ff, rsp_face_in;
   logic [1:0]            rsp_edge_ff, rsp_edge_in;
   logic                  rsp_end_ff, rsp_end_in;
   vertex_type            rsp_near_ff, rsp_near_in;
   logic [2:0][FAR_W-1:0] rsp_far_ff, rsp_far_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  rsp_load;

   // stores
   logic                  vram_wr, vram_rd, fram_wr, fram_rd;
   logic [IDX_W-1:0]      vram_raddr;
   vertex_type            vram_q;
   face_type              fram_q, fram_d;

   logic [1:0]            jsel;
   logic [1:0]            vidx;
   logic [2:0]            jmask;
   logic [2:0]            sil_rest;
   vertex_type            vsel;

   assign csr_ready = 1'b1;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         light_in[i] = light_ff[i];
      end
      if (csr_valid) begin
         unique case (csr_index)
            REG_LIGHT_X: light_in[0] = csr_data;
            REG_LIGHT_Y: light_in[1] = csr_data;
            REG_LIGHT_Z: light_in[2] = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            light_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < 3; i++) begin
            light_ff[i] <= light_in[i];
         end
      end
   end

   assign pop     = (state_ff == ST_IDLE) && head.valid;
   assign vram_wr = pop && (head.item.cmd == CMD_VERTEX);
   assign fram_wr = pop && (head.item.cmd == CMD_FACE);
   assign fram_d  = '{nb: head.item.nb, corner: head.item.corner};
   assign fram_rd = (state_ff == ST_FACE_RD);
   assign vram_rd = (state_ff == ST_FACE_WT) || (state_ff == ST_V0) || (state_ff == ST_V1);

   always_comb begin
      case (state_ff)
         ST_FACE_WT: vram_raddr = fram_q.corner[0];
         ST_V0:      vram_raddr = corner_ff[1];
         default:    vram_raddr = corner_ff[2];
      endcase
   end

   ssee_ram #(.WIDTH($bits(vertex_type)), .DEPTH(VTX_DEPTH)) u_vram (
      .clock  (clock),
      .wr_en  (vram_wr),
      .wr_addr(head.item.slot),
      .wr_data(head.item.pos),
      .rd_en  (vram_rd),
      .rd_addr(vram_raddr),
      .rd_data(vram_q)
   );

   ssee_ram #(.WIDTH($bits(face_type)), .DEPTH(FACE_DEPTH)) u_fram (
      .clock  (clock),
      .wr_en  (fram_wr),
      .wr_addr(head.item.slot),
      .wr_data(fram_d),
      .rd_en  (fram_rd),
      .rd_addr(cur_face_ff),
      .rd_data(fram_q)
   );

   // side = ((q-p) x (r-p)) . (light-p); the plane value at the light
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         u_in[i] = {q_ff[i][15], q_ff[i]} - {p_ff[i][15], p_ff[i]};
         w_in[i] = {r_ff[i][15], r_ff[i]} - {p_ff[i][15], p_ff[i]};
         e_in[i] = {light_ff[i][15], light_ff[i]} - {p_ff[i][15], p_ff[i]};
      end
      m_in[0] = $signed({{17{u_ff[1][16]}}, u_ff[1]}) * $signed({{17{w_ff[2][16]}}, w_ff[2]});
      m_in[1] = $signed({{17{u_ff[2][16]}}, u_ff[2]}) * $signed({{17{w_ff[1][16]}}, w_ff[1]});
      m_in[2] = $signed({{17{u_ff[2][16]}}, u_ff[2]}) * $signed({{17{w_ff[0][16]}}, w_ff[0]});
      m_in[3] = $signed({{17{u_ff[0][16]}}, u_ff[0]}) * $signed({{17{w_ff[2][16]}}, w_ff[2]});
      m_in[4] = $signed({{17{u_ff[0][16]}}, u_ff[0]}) * $signed({{17{w_ff[1][16]}}, w_ff[1]});
      m_in[5] = $signed({{17{u_ff[1][16]}}, u_ff[1]}) * $signed({{17{w_ff[0][16]}}, w_ff[0]});
      for (int i = 0; i < 3; i++) begin
         n_in[i] = {m_ff[2*i][33], m_ff[2*i]} - {m_ff[2*i+1][33], m_ff[2*i+1]};
         t_in[i] = $signed({{17{n_ff[i][34]}}, n_ff[i]}) *
                   $signed({{35{e3_ff[i][16]}}, e3_ff[i]});
      end
      side = {{2{t_ff[0][51]}}, t_ff[0]} + {{2{t_ff[1][51]}}, t_ff[1]} +
             {{2{t_ff[2][51]}}, t_ff[2]};
      lit  = !side[53] && (side != '0);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         u_ff[i]  <= u_in[i];
         w_ff[i]  <= w_in[i];
         e_ff[i]  <= e_in[i];
         e2_ff[i] <= e_ff[i];
         e3_ff[i] <= e2_ff[i];
         n_ff[i]  <= n_in[i];
         t_ff[i]  <= t_in[i];
      end
      for (int i = 0; i < 6; i++) begin
         m_ff[i] <= m_in[i];
      end
   end

   // lowest pending edge and the corner of the current endpoint
   always_comb begin
      if (sil_ff[0]) begin
         jsel = 2'd0;
      end else if (sil_ff[1]) begin
         jsel = 2'd1;
      end else begin
         jsel = 2'd2;
      end
      jmask    = 3'b001 << jsel;
      sil_rest = sil_ff & ~jmask;
      if (!end_ff) begin
         vidx = jsel;
      end else if (jsel == 2'd2) begin
         vidx = 2'd0;
      end else begin
         vidx = jsel + 2'd1;
      end
      vsel = vq_ff[vidx];
   end

   assign rsp_load = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in    = state_ff;
      cur_face_in = cur_face_ff;
      qface_in    = qface_ff;
      self_in     = self_ff;
      corner_in   = corner_ff;
      nb_in       = nb_ff;
      p_in        = p_ff;
      q_in        = q_ff;
      r_in        = r_ff;
      vq_in       = vq_ff;
      sil_in      = sil_ff;
      nk_in       = nk_ff;
      cnt_in      = cnt_ff;
      end_in      = end_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop && (head.item.cmd == CMD_QUERY)) begin
               cur_face_in = head.item.slot;
               qface_in    = head.item.slot;
               self_in     = 1'b1;
               sil_in      = '0;
               state_in    = ST_FACE_RD;
            end
         end
         ST_FACE_RD: state_in = ST_FACE_WT;
         ST_FACE_WT: begin
            corner_in = fram_q.corner;
            if (self_ff) begin
               nb_in = fram_q.nb;
            end
            state_in = ST_V0;
         end
         ST_V0: begin
            p_in     = vram_q;
            state_in = ST_V1;
         end
         ST_V1: begin
            q_in     = vram_q;
            state_in = ST_V2;
         end
         ST_V2: begin
            r_in     = vram_q;
            cnt_in   = '0;
            state_in = ST_CALC;
         end
         ST_CALC: begin
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == CALC_LAST) begin
               if (self_ff) begin
                  if (lit) begin
                     vq_in    = '{r_ff, q_ff, p_ff};
                     nk_in    = '0;
                     state_in = ST_NB;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  sil_in[nk_ff] = !lit;
                  nk_in         = nk_ff + 2'd1;
                  state_in      = ST_NB;
               end
            end
         end
         ST_NB: begin
            if (nk_ff == 2'd3) begin
               state_in = (sil_ff != '0) ? ST_EMIT : ST_IDLE;
               end_in   = 1'b0;
            end else if (nb_ff[nk_ff][NB_W-1]) begin
               // missing neighbour
               sil_in[nk_ff] = 1'b1;
               nk_in         = nk_ff + 2'd1;
            end else begin
               cur_face_in = nb_ff[nk_ff][IDX_W-1:0];
               self_in     = 1'b0;
               state_in    = ST_FACE_RD;
            end
         end
         ST_EMIT: begin
            if (rsp_load) begin
               end_in = !end_ff;
               if (end_ff) begin
                  sil_in = sil_rest;
                  if (sil_rest == '0) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      logic [FAR_W-1:0] v24;
      logic [FAR_W-1:0] l24;
      rsp_face_in = qface_ff;
      rsp_edge_in = jsel;
      rsp_end_in  = end_ff;
      rsp_near_in = vsel;
      rsp_last_in = end_ff && (sil_rest == '0);
      for (int i = 0; i < 3; i++) begin
         v24 = {{(FAR_W-COORD_W){vsel[i][COORD_W-1]}}, vsel[i]};
         l24 = {{(FAR_W-COORD_W){light_ff[i][COORD_W-1]}}, light_ff[i]};
         rsp_far_in[i] = v24 + (v24 - l24) * EXTRUDE_FACTOR;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_face_ff <= cur_face_in;
      qface_ff    <= qface_in;
      self_ff     <= self_in;
      corner_ff   <= corner_in;
      nb_ff       <= nb_in;
      p_ff        <= p_in;
      q_ff        <= q_in;
      r_ff        <= r_in;
      vq_ff       <= vq_in;
      sil_ff      <= sil_in;
      nk_ff       <= nk_in;
      cnt_ff      <= cnt_in;
      end_ff      <= end_in;
      if (rsp_load) begin
         rsp_face_ff <= rsp_face_in;
         rsp_edge_ff <= rsp_edge_in;
         rsp_end_ff  <= rsp_end_in;
         rsp_near_ff <= rsp_near_in;
         rsp_far_ff  <= rsp_far_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_far_ff, rsp_near_ff, rsp_face_ff};
   assign rsp_tuser  = {rsp_end_ff, rsp_edge_ff};
   assign rsp_tlast  = rsp_last_ff;

   `SSEE_ASSERT(a_emit_pending, state_ff == ST_EMIT |-> sil_ff != '0,
      "emitting with no silhouette edge pending")
   `SSEE_ASSERT(a_last_ends, rsp_load && rsp_last_in |=> state_ff == ST_IDLE,
      "last result did not end the query")
   `SSEE_ASSERT(a_calc_bound, state_ff == ST_CALC |-> cnt_ff <= CALC_LAST,
      "plane test ran past its last stage")
endmodule

@@ design/shadow_silhouette_edge_extruder_core.sv @@
// Loads run one per cycle once queued, while the back end is idle; a query tests the query
// face and, if that face is lit, every present neighbour (face read, three vertex reads,
// plane test), then emits one result per endpoint of each silhouette edge.
// A four-entry request queue lets requests arrive while a query is in progress.
// Synchronous active-high reset clears control and the light registers; the vertex
// and face stores hold nothing defined until loaded.
module shadow_silhouette_edge_extruder_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,  // slot, pos_x, pos_y, pos_z, corner_a..c, neighbour_a..c
   input  logic [1:0]   req_tuser,  // command
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [135:0] rsp_tdata,  // face_index, near_x, near_y, near_z, far_x, far_y, far_z
   output logic [2:0]   rsp_tuser,  // edge_slot, endpoint
   output logic         rsp_tlast,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [15:0]  csr_data
);
   import ssee_pkg::*;

   q_head_type head;
   logic       pop;

   ssee_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .head      (head),
      .pop       (pop)
   );

   ssee_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );
endmodule
